### src/rotation_vector_to_rotation_matrix_unit_macros.svh
// assertion macros for the rotation vector to rotation matrix unit
`ifndef ROTATION_VECTOR_TO_ROTATION_MATRIX_UNIT_MACROS_SVH
`define ROTATION_VECTOR_TO_ROTATION_MATRIX_UNIT_MACROS_SVH

// property that must hold in the same cycle
`define RVRM_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// property whose consequence is checked in the next cycle
`define RVRM_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

### src/rvrm_pkg.sv
// shared types, constants and arithmetic helpers of the rotation matrix unit
package rvrm_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 31;

	localparam logic signed [35:0] ONE_Q30 = 36'sd1073741824;
	localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
	localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
	localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
	localparam logic signed [35:0] GAIN_Q30 = 36'sd652032874;
	localparam logic [34:0] TWO_PI_U = 35'd6746518852;
	localparam logic [34:0] FOUR_PI_U = 35'd13493037704;

	// sign and magnitude of the input vector, plus low bits for the tiny-angle path
	typedef struct packed {
		logic signed [2:0] vx;
		logic signed [2:0] vy;
		logic signed [2:0] vz;
		logic [2:0] neg;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [31:0] mag_z;
	} vec_t;

	typedef struct packed {
		logic tiny;
		vec_t vec;
		logic [31:0] theta;
	} root_t;

	typedef struct packed {
		logic tiny;
		logic signed [2:0] vx;
		logic signed [2:0] vy;
		logic signed [2:0] vz;
		logic [31:0] theta;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
	} axis_t;

	typedef struct packed {
		logic tiny;
		logic signed [2:0] vx;
		logic signed [2:0] vy;
		logic signed [2:0] vz;
		logic signed [31:0] ux;
		logic signed [31:0] uy;
		logic signed [31:0] uz;
		logic signed [31:0] sn;
		logic signed [32:0] omc;
	} trig_t;

	typedef struct packed {
		logic signed [31:0] m00;
		logic signed [31:0] m01;
		logic signed [31:0] m02;
		logic signed [31:0] m10;
		logic signed [31:0] m11;
		logic signed [31:0] m12;
		logic signed [31:0] m20;
		logic signed [31:0] m21;
		logic signed [31:0] m22;
	} mat_t;

	// atan(2^-i) in q.30
	function automatic logic [31:0] atan_val(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd843314857;
			1: r = 32'd497837829;
			2: r = 32'd263043837;
			3: r = 32'd133525159;
			4: r = 32'd67021687;
			5: r = 32'd33543516;
			6: r = 32'd16775851;
			7: r = 32'd8388437;
			8: r = 32'd4194283;
			9: r = 32'd2097149;
			default: r = (i <= 30) ? (32'd1 << (30 - i)) : 32'd0;
		endcase
		return r;
	endfunction

	// divide by 2^30, rounding half away from zero
	function automatic logic signed [37:0] round30(input logic signed [67:0] v);
		logic [67:0] mag;
		logic [67:0] r;
		mag = v[67] ? 68'(-v) : 68'(v);
		r = (mag + 68'd536870912) >> 30;
		return v[67] ? -$signed(r[37:0]) : $signed(r[37:0]);
	endfunction

	// saturate to [-1, 1] in q2.30
	function automatic logic signed [31:0] clamp_q30(input logic signed [37:0] v);
		logic signed [31:0] r;
		if (v > 38'sd1073741824) r = 32'sd1073741824;
		else if (v < -38'sd1073741824) r = -32'sd1073741824;
		else r = v[31:0];
		return r;
	endfunction

endpackage

### src/rvrm_sqrt.sv
// sum of squares and one-bit-per-stage integer square root
module rvrm_sqrt import rvrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input vec_t in_vec,
	output logic out_valid,
	output root_t out_root
);

	logic vld_s1;
	vec_t vec_s1;
	logic [63:0] px_s1, py_s1, pz_s1;
	logic vld_s2;
	vec_t vec_s2;
	logic [63:0] sum_s2;

	logic rt_vld_s [SQRT_STEPS];
	vec_t rt_vec_s [SQRT_STEPS];
	logic rt_small_s [SQRT_STEPS];
	logic [33:0] rt_rem_s [SQRT_STEPS];
	logic [31:0] rt_root_s [SQRT_STEPS];
	logic [63:0] rt_bits_s [SQRT_STEPS];

	// squares then their sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s1 <= in_vec;
			px_s1 <= in_vec.mag_x * in_vec.mag_x;
			py_s1 <= in_vec.mag_y * in_vec.mag_y;
			pz_s1 <= in_vec.mag_z * in_vec.mag_z;
			vec_s2 <= vec_s1;
			sum_s2 <= px_s1 + py_s1 + pz_s1;
		end
	end

	// one result bit per stage
	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		logic v_in;
		vec_t vec_in;
		logic small_in;
		logic [33:0] rem_in;
		logic [31:0] root_in;
		logic [63:0] bits_in;
		logic [35:0] rsh, trial, diff;

		if (k == 0) begin : g_first
			assign v_in = vld_s2;
			assign vec_in = vec_s2;
			assign small_in = (sum_s2 < 64'd8);
			assign rem_in = '0;
			assign root_in = '0;
			assign bits_in = sum_s2;
		end else begin : g_next
			assign v_in = rt_vld_s[k-1];
			assign vec_in = rt_vec_s[k-1];
			assign small_in = rt_small_s[k-1];
			assign rem_in = rt_rem_s[k-1];
			assign root_in = rt_root_s[k-1];
			assign bits_in = rt_bits_s[k-1];
		end

		assign rsh = {rem_in, bits_in[63:62]};
		assign trial = {2'b00, root_in, 2'b01};
		assign diff = rsh - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[k] <= 1'b0;
			end else if (en) begin
				rt_vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rsh >= trial) begin
					rt_rem_s[k] <= diff[33:0];
					rt_root_s[k] <= {root_in[30:0], 1'b1};
				end else begin
					rt_rem_s[k] <= rsh[33:0];
					rt_root_s[k] <= {root_in[30:0], 1'b0};
				end
				rt_bits_s[k] <= {bits_in[61:0], 2'b00};
				rt_vec_s[k] <= vec_in;
				rt_small_s[k] <= small_in;
			end
		end
	end

	assign out_valid = rt_vld_s[SQRT_STEPS-1];

	always_comb begin
		out_root.tiny = rt_small_s[SQRT_STEPS-1];
		out_root.vec = rt_vec_s[SQRT_STEPS-1];
		out_root.theta = rt_root_s[SQRT_STEPS-1];
	end

endmodule

### src/rvrm_div.sv
// three restoring dividers forming the unit axis, one quotient bit per stage
module rvrm_div import rvrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input root_t in_root,
	output logic out_valid,
	output axis_t out_axis
);

	logic dv_vld_s [DIV_STEPS+1];
	root_t dv_info_s [DIV_STEPS+1];
	logic [31:0] dv_rem_s [DIV_STEPS+1][3];
	logic [30:0] dv_bits_s [DIV_STEPS+1][3];
	logic [30:0] dv_q_s [DIV_STEPS+1][3];

	logic [31:0] mag_in [3];
	logic [30:0] q_out [3];
	logic signed [31:0] u_out [3];

	assign mag_in[0] = in_root.vec.mag_x;
	assign mag_in[1] = in_root.vec.mag_y;
	assign mag_in[2] = in_root.vec.mag_z;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DIV_STEPS; k++) dv_vld_s[k] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= in_valid;
			for (int k = 1; k <= DIV_STEPS; k++) dv_vld_s[k] <= dv_vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_info_s[0] <= in_root;
			for (int k = 1; k <= DIV_STEPS; k++) dv_info_s[k] <= dv_info_s[k-1];
		end
	end

	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [61:0] dividend;

		// dividend with half the divisor added for rounding
		assign dividend = {mag_in[l], 30'd0} + 62'(in_root.theta[31:1]);

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem_s[0][l] <= {1'b0, dividend[61:31]};
				dv_bits_s[0][l] <= dividend[30:0];
				dv_q_s[0][l] <= '0;
			end
		end

		for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
			logic [32:0] rsh, dsr, diff;
			logic ge;

			assign rsh = {dv_rem_s[k-1][l], dv_bits_s[k-1][l][30]};
			assign dsr = {1'b0, dv_info_s[k-1].theta};
			assign diff = rsh - dsr;
			assign ge = (rsh >= dsr);

			always_ff @(posedge clk) begin
				if (en) begin
					dv_rem_s[k][l] <= ge ? diff[31:0] : rsh[31:0];
					dv_bits_s[k][l] <= {dv_bits_s[k-1][l][29:0], 1'b0};
					dv_q_s[k][l] <= {dv_q_s[k-1][l][29:0], ge};
				end
			end
		end

		// clamp to one and restore the sign
		assign q_out[l] = (dv_q_s[DIV_STEPS][l] > 31'd1073741824) ? 31'd1073741824
			: dv_q_s[DIV_STEPS][l];
		assign u_out[l] = dv_info_s[DIV_STEPS].vec.neg[l] ? -$signed({1'b0, q_out[l]})
			: $signed({1'b0, q_out[l]});
	end

	assign out_valid = dv_vld_s[DIV_STEPS];

	always_comb begin
		out_axis.tiny = dv_info_s[DIV_STEPS].tiny;
		out_axis.vx = dv_info_s[DIV_STEPS].vec.vx;
		out_axis.vy = dv_info_s[DIV_STEPS].vec.vy;
		out_axis.vz = dv_info_s[DIV_STEPS].vec.vz;
		out_axis.theta = dv_info_s[DIV_STEPS].theta;
		out_axis.ux = u_out[0];
		out_axis.uy = u_out[1];
		out_axis.uz = u_out[2];
	end

endmodule

### src/rvrm_cordic.sv
// angle reduction and pipelined rotation-mode cordic for sin and cos
module rvrm_cordic import rvrm_pkg::*; #(
	parameter int ITER = 30
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input axis_t in_axis,
	output logic out_valid,
	output trig_t out_trig
);

	logic vld_s1, vld_s2;
	axis_t axis_s1, axis_s2;
	logic [34:0] ang_s1;
	logic signed [35:0] ang_s2;
	logic flip_s2;

	logic [34:0] a0;
	logic signed [35:0] aw, af;
	logic ff;

	logic cr_vld_s [ITER];
	axis_t cr_axis_s [ITER];
	logic cr_flip_s [ITER];
	logic signed [35:0] cr_x_s [ITER];
	logic signed [35:0] cr_y_s [ITER];
	logic signed [35:0] cr_a_s [ITER];

	logic signed [31:0] xc, cs;

	// theta modulo two pi, theta stays below three turns
	assign a0 = {1'b0, in_axis.theta, 2'b00};

	// wrap to (-pi, pi] then fold into [-pi/2, pi/2]
	always_comb begin
		aw = $signed({1'b0, ang_s1});
		if (aw > PI_Q30) aw = aw - TWO_PI_Q30;
		ff = 1'b0;
		af = aw;
		if (aw > HALF_PI_Q30) begin
			af = PI_Q30 - aw;
			ff = 1'b1;
		end else if (aw < -HALF_PI_Q30) begin
			af = -PI_Q30 - aw;
			ff = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			axis_s1 <= in_axis;
			if (a0 >= FOUR_PI_U) ang_s1 <= a0 - FOUR_PI_U;
			else if (a0 >= TWO_PI_U) ang_s1 <= a0 - TWO_PI_U;
			else ang_s1 <= a0;
			axis_s2 <= axis_s1;
			ang_s2 <= af;
			flip_s2 <= ff;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < ITER; i++) begin : g_iter
		logic v_in, f_in;
		axis_t ax_in;
		logic signed [35:0] x_in, y_in, a_in, dx, dy, at;

		if (i == 0) begin : g_first
			assign v_in = vld_s2;
			assign ax_in = axis_s2;
			assign f_in = flip_s2;
			assign x_in = GAIN_Q30;
			assign y_in = '0;
			assign a_in = ang_s2;
		end else begin : g_next
			assign v_in = cr_vld_s[i-1];
			assign ax_in = cr_axis_s[i-1];
			assign f_in = cr_flip_s[i-1];
			assign x_in = cr_x_s[i-1];
			assign y_in = cr_y_s[i-1];
			assign a_in = cr_a_s[i-1];
		end

		assign dx = y_in >>> i;
		assign dy = x_in >>> i;
		assign at = $signed({4'b0000, atan_val(i)});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_vld_s[i] <= 1'b0;
			end else if (en) begin
				cr_vld_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (a_in >= 0) begin
					cr_x_s[i] <= x_in - dx;
					cr_y_s[i] <= y_in + dy;
					cr_a_s[i] <= a_in - at;
				end else begin
					cr_x_s[i] <= x_in + dx;
					cr_y_s[i] <= y_in - dy;
					cr_a_s[i] <= a_in + at;
				end
				cr_axis_s[i] <= ax_in;
				cr_flip_s[i] <= f_in;
			end
		end
	end

	// clamp, undo the fold and form 1 - cos
	assign xc = clamp_q30(38'(cr_x_s[ITER-1]));
	assign cs = cr_flip_s[ITER-1] ? -xc : xc;
	assign out_valid = cr_vld_s[ITER-1];

	always_comb begin
		out_trig.tiny = cr_axis_s[ITER-1].tiny;
		out_trig.vx = cr_axis_s[ITER-1].vx;
		out_trig.vy = cr_axis_s[ITER-1].vy;
		out_trig.vz = cr_axis_s[ITER-1].vz;
		out_trig.ux = cr_axis_s[ITER-1].ux;
		out_trig.uy = cr_axis_s[ITER-1].uy;
		out_trig.uz = cr_axis_s[ITER-1].uz;
		out_trig.sn = clamp_q30(38'(cr_y_s[ITER-1]));
		out_trig.omc = 33'sd1073741824 - 33'(cs);
	end

endmodule

### src/rvrm_mat.sv
// skew products and assembly of the nine matrix entries
module rvrm_mat import rvrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input trig_t in_trig,
	output logic out_valid,
	output mat_t out_mat
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	trig_t trig_s1, trig_s2, trig_s3;
	logic signed [63:0] pxx_s1, pyy_s1, pzz_s1, pxy_s1, pxz_s1, pyz_s1;
	logic signed [63:0] psx_s1, psy_s1, psz_s1;
	logic signed [32:0] kd0_s2, kd1_s2, kd2_s2, kxy_s2, kxz_s2, kyz_s2;
	logic signed [32:0] skx_s2, sky_s2, skz_s2;
	logic signed [65:0] ed0_s3, ed1_s3, ed2_s3, exy_s3, exz_s3, eyz_s3;
	logic signed [32:0] skx_s3, sky_s3, skz_s3;
	mat_t mat_s4;

	logic signed [31:0] fx, fy, fz;

	// one matrix entry: identity part, sine term and versine term
	function automatic logic signed [31:0] entry(input logic diag,
			input logic signed [32:0] sk, input logic signed [65:0] e);
		logic signed [37:0] acc;
		acc = round30(68'(e)) + 38'(sk) + (diag ? 38'sd1073741824 : 38'sd0);
		return clamp_q30(acc);
	endfunction

	// tiny angle: four times the raw vector
	assign fx = 32'(trig_s3.vx) * 32'sd4;
	assign fy = 32'(trig_s3.vy) * 32'sd4;
	assign fz = 32'(trig_s3.vz) * 32'sd4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// axis products and sine times axis
			trig_s1 <= in_trig;
			pxx_s1 <= 64'(in_trig.ux) * 64'(in_trig.ux);
			pyy_s1 <= 64'(in_trig.uy) * 64'(in_trig.uy);
			pzz_s1 <= 64'(in_trig.uz) * 64'(in_trig.uz);
			pxy_s1 <= 64'(in_trig.ux) * 64'(in_trig.uy);
			pxz_s1 <= 64'(in_trig.ux) * 64'(in_trig.uz);
			pyz_s1 <= 64'(in_trig.uy) * 64'(in_trig.uz);
			psx_s1 <= 64'(in_trig.sn) * 64'(in_trig.ux);
			psy_s1 <= 64'(in_trig.sn) * 64'(in_trig.uy);
			psz_s1 <= 64'(in_trig.sn) * 64'(in_trig.uz);

			// entries of k squared and sine terms in q3.30
			trig_s2 <= trig_s1;
			kd0_s2 <= 33'(round30(68'(-(pzz_s1 + pyy_s1))));
			kd1_s2 <= 33'(round30(68'(-(pzz_s1 + pxx_s1))));
			kd2_s2 <= 33'(round30(68'(-(pyy_s1 + pxx_s1))));
			kxy_s2 <= 33'(round30(68'(pxy_s1)));
			kxz_s2 <= 33'(round30(68'(pxz_s1)));
			kyz_s2 <= 33'(round30(68'(pyz_s1)));
			skx_s2 <= 33'(round30(68'(psx_s1)));
			sky_s2 <= 33'(round30(68'(psy_s1)));
			skz_s2 <= 33'(round30(68'(psz_s1)));

			// versine times k squared
			trig_s3 <= trig_s2;
			ed0_s3 <= 66'(trig_s2.omc) * 66'(kd0_s2);
			ed1_s3 <= 66'(trig_s2.omc) * 66'(kd1_s2);
			ed2_s3 <= 66'(trig_s2.omc) * 66'(kd2_s2);
			exy_s3 <= 66'(trig_s2.omc) * 66'(kxy_s2);
			exz_s3 <= 66'(trig_s2.omc) * 66'(kxz_s2);
			eyz_s3 <= 66'(trig_s2.omc) * 66'(kyz_s2);
			skx_s3 <= skx_s2;
			sky_s3 <= sky_s2;
			skz_s3 <= skz_s2;

			// final sum and saturation, or the small-angle matrix for a tiny angle
			if (trig_s3.tiny) begin
				mat_s4.m00 <= 32'sd1073741824;
				mat_s4.m01 <= -fz;
				mat_s4.m02 <= fy;
				mat_s4.m10 <= fz;
				mat_s4.m11 <= 32'sd1073741824;
				mat_s4.m12 <= -fx;
				mat_s4.m20 <= -fy;
				mat_s4.m21 <= fx;
				mat_s4.m22 <= 32'sd1073741824;
			end else begin
				mat_s4.m00 <= entry(1'b1, 33'sd0, ed0_s3);
				mat_s4.m01 <= entry(1'b0, -skz_s3, exy_s3);
				mat_s4.m02 <= entry(1'b0, sky_s3, exz_s3);
				mat_s4.m10 <= entry(1'b0, skz_s3, exy_s3);
				mat_s4.m11 <= entry(1'b1, 33'sd0, ed1_s3);
				mat_s4.m12 <= entry(1'b0, -skx_s3, eyz_s3);
				mat_s4.m20 <= entry(1'b0, -sky_s3, exz_s3);
				mat_s4.m21 <= entry(1'b0, skx_s3, eyz_s3);
				mat_s4.m22 <= entry(1'b1, 33'sd0, ed2_s3);
			end
		end
	end

	assign out_valid = vld_s4;
	assign out_mat = mat_s4;

endmodule

### src/rotation_vector_to_rotation_matrix_unit.sv
// top level of the rotation vector to rotation matrix unit
//
// channel  direction  handshake            payload
// in       request    in_valid / in_stall   rot_x rot_y rot_z (q4.28)
// out      result     out_valid / out_stall m00 .. m22 (q2.30)
//
// one request per cycle while in_stall is low; the pipeline holds the 32-stage square root,
// the 32-stage axis dividers and one cordic stage per iteration, plus squaring, reduction and
// matrix assembly stages.
// reset clears only the valid bits of the pipeline.
// a stall on the output while out_valid is high freezes every stage and is passed straight back to in_stall.
module rotation_vector_to_rotation_matrix_unit import rvrm_pkg::*; #(
	parameter int CORDIC_ITERATIONS = 30
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [31:0] rot_x,
	input logic signed [31:0] rot_y,
	input logic signed [31:0] rot_z,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] m00,
	output logic signed [31:0] m01,
	output logic signed [31:0] m02,
	output logic signed [31:0] m10,
	output logic signed [31:0] m11,
	output logic signed [31:0] m12,
	output logic signed [31:0] m20,
	output logic signed [31:0] m21,
	output logic signed [31:0] m22
);

	`include "rotation_vector_to_rotation_matrix_unit_macros.svh"

	logic en;
	vec_t vec;
	logic sq_valid, dv_valid, cr_valid;
	root_t root;
	axis_t axis;
	trig_t trig;
	mat_t mat;

	// whole pipeline advances unless a finished result is held
	assign en = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	// split the request into sign and magnitude
	always_comb begin
		vec.vx = rot_x[2:0];
		vec.vy = rot_y[2:0];
		vec.vz = rot_z[2:0];
		vec.neg = {rot_z[31], rot_y[31], rot_x[31]};
		vec.mag_x = rot_x[31] ? 32'(-rot_x) : 32'(rot_x);
		vec.mag_y = rot_y[31] ? 32'(-rot_y) : 32'(rot_y);
		vec.mag_z = rot_z[31] ? 32'(-rot_z) : 32'(rot_z);
	end

	rvrm_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(in_valid), .in_vec(vec),
		.out_valid(sq_valid), .out_root(root)
	);

	rvrm_div u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(sq_valid), .in_root(root),
		.out_valid(dv_valid), .out_axis(axis)
	);

	rvrm_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(dv_valid), .in_axis(axis),
		.out_valid(cr_valid), .out_trig(trig)
	);

	rvrm_mat u_mat (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(cr_valid), .in_trig(trig),
		.out_valid(out_valid), .out_mat(mat)
	);

	assign m00 = mat.m00;
	assign m01 = mat.m01;
	assign m02 = mat.m02;
	assign m10 = mat.m10;
	assign m11 = mat.m11;
	assign m12 = mat.m12;
	assign m20 = mat.m20;
	assign m21 = mat.m21;
	assign m22 = mat.m22;

	// checks
	`RVRM_CHECK(a_m00_range, out_valid |-> (m00 <= 32'sd1073741824 && m00 >= -32'sd1073741824), "m00 outside [-1, 1]")
	`RVRM_CHECK(a_m12_range, out_valid |-> (m12 <= 32'sd1073741824 && m12 >= -32'sd1073741824), "m12 outside [-1, 1]")
	`RVRM_CHECK_NEXT(a_stall_keeps, in_stall, out_valid, "held result lost during stall")

endmodule

### sim/rotation_vector_to_rotation_matrix_unit_test.sv
// testbench of the rotation vector to rotation matrix unit against a built-in rodrigues predictor
module rotation_vector_to_rotation_matrix_unit_test;
	import rvrm_pkg::*;

	localparam int ITERS = 30;
	localparam int LATENCY = 72 + ITERS;
	localparam int RANDOM_REQUESTS = 1630;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] rot_x = '0;
	logic signed [31:0] rot_y = '0;
	logic signed [31:0] rot_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;

	// expected matrices, oldest first
	mat_t pending_matrices[$];
	int mismatch_count = 0;
	int checked_count = 0;
	int sent_count = 0;
	int wait_left = -1;
	bit draining = 1'b0;

	rotation_vector_to_rotation_matrix_unit #(.CORDIC_ITERATIONS(ITERS)) dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22)
	);

	always #4 clk = ~clk;

	// v / 2^n rounded half away from zero
	function automatic longint shift_round(input longint v, input int n);
		longint half;
		half = longint'(1) << (n - 1);
		if (v >= 0) return (v + half) >>> n;
		return -((-v + half) >>> n);
	endfunction

	// v / 2^n rounded toward minus infinity
	function automatic longint shift_floor(input longint v, input int n);
		if (v >= 0) return v >>> n;
		return -((-v - 1) >>> n) - 1;
	endfunction

	function automatic longint unit_sat(input longint v);
		if (v > 64'sd1073741824) return 64'sd1073741824;
		if (v < -64'sd1073741824) return -64'sd1073741824;
		return v;
	endfunction

	function automatic longint unsigned int_sqrt(input longint unsigned s);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// rodrigues matrix of one rotation vector
	function automatic mat_t rodrigues_matrix(input logic signed [31:0] rx,
			input logic signed [31:0] ry, input logic signed [31:0] rz);
		longint w[3], k[3][3], k2[3][3], r[3][3];
		longint unsigned s, t, mag;
		longint q, a, x, y, dx, dy, sn, cs, omc;
		bit flip;
		mat_t m;
		w[0] = rx; w[1] = ry; w[2] = rz;
		s = 0;
		for (int i = 0; i < 3; i++) s += longint'(w[i] * w[i]);
		sn = 0; omc = 0;
		if (s >= 8) begin
			t = int_sqrt(s);
			for (int i = 0; i < 3; i++) begin
				mag = (w[i] < 0) ? -w[i] : w[i];
				q = unit_sat(longint'(((mag << 30) + (t >> 1)) / t));
				w[i] = (w[i] < 0) ? -q : q;
			end
			// range reduction then cordic in rotation mode
			a = longint'(t << 2) % longint'(TWO_PI_Q30);
			flip = 1'b0;
			if (a > longint'(PI_Q30)) a -= longint'(TWO_PI_Q30);
			if (a > longint'(HALF_PI_Q30)) begin
				a = longint'(PI_Q30) - a;
				flip = 1'b1;
			end else if (a < -longint'(HALF_PI_Q30)) begin
				a = -longint'(PI_Q30) - a;
				flip = 1'b1;
			end
			x = longint'(GAIN_Q30);
			y = 0;
			for (int i = 0; i < ITERS; i++) begin
				dx = shift_floor(y, i);
				dy = shift_floor(x, i);
				if (a >= 0) begin
					x -= dx; y += dy; a -= longint'(atan_val(i));
				end else begin
					x += dx; y -= dy; a += longint'(atan_val(i));
				end
			end
			sn = unit_sat(y);
			cs = flip ? -unit_sat(x) : unit_sat(x);
			omc = longint'(ONE_Q30) - cs;
		end
		k[0][0] = 0; k[0][1] = -w[2]; k[0][2] = w[1];
		k[1][0] = w[2]; k[1][1] = 0; k[1][2] = -w[0];
		k[2][0] = -w[1]; k[2][1] = w[0]; k[2][2] = 0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				k2[i][j] = 0;
				for (int n = 0; n < 3; n++) k2[i][j] += k[i][n] * k[n][j];
				r[i][j] = (i == j) ? longint'(ONE_Q30) : 0;
				if (s < 8)
					r[i][j] += 4 * k[i][j] + shift_round(k2[i][j], 27);
				else
					r[i][j] += shift_round(sn * k[i][j], 30)
						+ shift_round(omc * shift_round(k2[i][j], 30), 30);
				r[i][j] = unit_sat(r[i][j]);
			end
		m.m00 = r[0][0]; m.m01 = r[0][1]; m.m02 = r[0][2];
		m.m10 = r[1][0]; m.m11 = r[1][1]; m.m12 = r[1][2];
		m.m20 = r[2][0]; m.m21 = r[2][1]; m.m22 = r[2][2];
		return m;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked_count);
	endtask

	// send one request after a random gap
	task automatic send_vector(input logic [31:0] vx, input logic [31:0] vy,
			input logic [31:0] vz);
		int gap;
		gap = $urandom_range(4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rot_x <= vx; rot_y <= vy; rot_z <= vz;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_matrices.push_back(rodrigues_matrix(vx, vy, vz));
		sent_count++;
		@(negedge clk);
	endtask

	// random per-result wait before taking it
	always @(negedge clk) begin
		if (!arst_n || draining) begin
			wait_left = -1;
			out_stall <= 1'b0;
		end else if (out_valid) begin
			if (wait_left < 0) wait_left = $urandom_range(4);
			if (wait_left > 0) begin
				wait_left--;
				out_stall <= 1'b1;
			end else begin
				wait_left = -1;
				out_stall <= 1'b0;
			end
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		mat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_matrices.size() == 0) begin
				report_mismatch("unexpected result", m00, 32'h0);
			end else begin
				want = pending_matrices.pop_front();
				if (m00 !== want.m00) report_mismatch("m00", m00, want.m00);
				if (m01 !== want.m01) report_mismatch("m01", m01, want.m01);
				if (m02 !== want.m02) report_mismatch("m02", m02, want.m02);
				if (m10 !== want.m10) report_mismatch("m10", m10, want.m10);
				if (m11 !== want.m11) report_mismatch("m11", m11, want.m11);
				if (m12 !== want.m12) report_mismatch("m12", m12, want.m12);
				if (m20 !== want.m20) report_mismatch("m20", m20, want.m20);
				if (m21 !== want.m21) report_mismatch("m21", m21, want.m21);
				if (m22 !== want.m22) report_mismatch("m22", m22, want.m22);
			end
			checked_count++;
		end
	end

	// zero, tiny, small-threshold, axis, full-scale, near multiples of pi and mixed vectors
	task automatic test_directed();
		send_vector(0, 0, 0);
		send_vector(1, 0, 0);
		send_vector(32'hFFFFFFFF, 1, 32'hFFFFFFFF);
		send_vector(2, 1, 1);
		send_vector(2, 2, 0);
		send_vector(0, 0, 3);
		send_vector(32'h7FFFFFFF, 0, 0);
		send_vector(32'h80000000, 0, 0);
		send_vector(0, 32'h80000000, 0);
		send_vector(0, 0, 32'h7FFFFFFF);
		send_vector(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		send_vector(32'h80000000, 32'h80000000, 32'h80000000);
		send_vector(32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_vector(32'h3243F6A9, 0, 0);          // near pi
		send_vector(32'h1921FB54, 0, 0);          // near pi/2
		send_vector(0, 32'h6487ED51, 0);          // near 2 pi
		send_vector(0, 0, 32'hCDBC0957);          // near -pi
		send_vector(32'h10000000, 32'h10000000, 32'hF0000000);
		send_vector(32'h55555555, 32'hAAAAAAAA, 32'h55555555);
		send_vector(32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA);
	endtask

	function automatic logic [31:0] random_component();
		case ($urandom_range(5))
			0: return $urandom_range(7) - 3;
			1: return $urandom_range(32'h1FFFF) - 32'h10000;
			2: return $urandom_range(32'h7FFFFFF) - 32'h4000000;
			default: return $urandom;
		endcase
	endfunction

	// random vectors of mixed magnitude
	task automatic test_random();
		for (int n = 0; n < RANDOM_REQUESTS; n++)
			send_vector(random_component(), random_component(), random_component());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random();
		in_valid <= 1'b0;
		draining = 1'b1;
		while (pending_matrices.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("sent %0d rotation vectors, checked %0d matrices, %0d mismatches",
			sent_count, checked_count, mismatch_count);
		if (mismatch_count == 0 && pending_matrices.size() == 0)
			$display("rotation_vector_to_rotation_matrix_unit_test: done, clean");
		else
			$display("rotation_vector_to_rotation_matrix_unit_test: done, errors");
		$finish;
	end

	// hard stop
	initial begin
		#2000000;
		$display("rotation_vector_to_rotation_matrix_unit_test: done, errors");
		$finish;
	end

endmodule
